>>> hw/rtl/krht_pkg.sv
// Package for the key range heat tracker.
// Holds parameter defaults, opcode, report and register codes, and the sequencer states.
// No dependencies.
package krht_pkg;

    localparam int BUCKETS_DEF   = 32;
    localparam int KEY_BITS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_HIT  = 1'b1;

    localparam logic KIND_HIT = 1'b0;
    localparam logic KIND_HOT = 1'b1;

    localparam logic [1:0] CFG_BOUNDARY_COUNT = 2'd0;
    localparam logic [1:0] CFG_SMOOTHING      = 2'd1;
    localparam logic [1:0] CFG_PERIOD         = 2'd2;

    localparam logic [5:0]  BOUNDARY_COUNT_RST = 6'd33;
    localparam logic [16:0] SMOOTHING_RST      = 17'd13107;
    localparam logic [23:0] PERIOD_RST         = 24'd1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_HIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_SUM
    } t_state;

endpackage

>>> hw/rtl/krht_ram.sv
// Generic single write port RAM with one registered read port.
// Used for the boundary key table; no dependencies.
module krht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/key_range_heat_tracker_unit.sv
// Key range heat tracker: a load beat writes one boundary; a hit runs binary search steps
// (each a RAM read, then a compare) over the boundary table, then reports its bucket.
// A hit that ends a period then recomputes the hotness of each bucket in use (restoring
// divider, two multiplies on one multiplier, write back).
// An output stall holds the hit report and each write back.
// Reset (synchronous, active low) clears hit counters, hotness, period progress and
// registers to their defaults; the boundary table is not cleared and must be loaded.
module key_range_heat_tracker_unit #(
    parameter int BUCKETS   = krht_pkg::BUCKETS_DEF,
    parameter int KEY_BITS  = krht_pkg::KEY_BITS_DEF,
    parameter int FRAC_BITS = krht_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_stall,
    input  logic                                         i_opcode,
    input  logic [5:0]                                   i_slot,
    input  logic [KEY_BITS-1:0]                          i_search_key,
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output logic                                         o_report_kind,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_bucket_index,
    output logic [FRAC_BITS:0]                           o_hotness_value,
    output logic                                         o_last_of_run,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [1:0]                                   i_cfg_index,
    input  logic [23:0]                                  i_cfg_data
);
    import krht_pkg::*;

    localparam int NW = $clog2(BUCKETS + 2);
    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW = $clog2(BUCKETS + 1);
    localparam int HW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS);
    localparam int PW = 17 + HW;
    localparam int SW = HW + 2;
    localparam logic [6:0]    NMAX = 7'(BUCKETS + 1);
    localparam logic [HW-1:0] ONE  = HW'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [5:0]          r_bc;
    logic [16:0]         r_alpha;
    logic [23:0]         r_per;
    logic [KEY_BITS-1:0] r_key;
    logic [NW-1:0]       r_lo, r_hi, r_nb, r_b;
    logic [23:0]         r_hits [BUCKETS];
    logic [HW-1:0]       r_hot  [BUCKETS];
    logic [23:0]         r_prog;
    logic [23:0]         r_rem;
    logic [HW-1:0]       r_q;
    logic [CW-1:0]       r_cnt;
    logic [PW-1:0]       r_p1, r_p2;

    logic          r_out_valid, r_kind, r_last;
    logic [IW-1:0] r_bidx;
    logic [HW-1:0] r_hotv;

    logic [6:0]          w_n7;
    logic [NW-1:0]       w_n, w_mid, w_lo_nx, w_hi_nx;
    logic [16:0]         w_alpha, w_inv;
    logic [23:0]         w_per, w_prog_nx, w_c;
    logic [KEY_BITS-1:0] w_rdata;
    logic [AW-1:0]       w_raddr;
    logic                w_gt, w_more, w_more0, w_free, w_accept, w_hit_last, w_run_last;
    logic                w_emit;
    logic [24:0]         w_sh;
    logic                w_ge;
    logic [IW-1:0]       w_idx, w_bi;
    logic [SW-1:0]       w_hsum;
    logic [HW-1:0]       w_hnew;
    logic [16:0]         w_ma;
    logic [HW-1:0]       w_mb;
    logic [PW-1:0]       w_prod;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_emit      = w_free && (r_state == ST_HIT || r_state == ST_SUM);

    // Effective register values after clamping.
    assign w_n7    = ({1'b0, r_bc} < 7'd2) ? 7'd2 : (({1'b0, r_bc} > NMAX) ? NMAX : {1'b0, r_bc});
    assign w_n     = w_n7[NW-1:0];
    assign w_alpha = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    assign w_inv   = 17'd65536 - w_alpha;
    assign w_per   = (r_per == 24'd0) ? 24'd1 : r_per;

    // Binary search step.
    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign w_raddr = w_mid[AW-1:0];
    assign w_gt    = w_rdata > r_key;
    assign w_lo_nx = w_gt ? r_lo : w_mid;
    assign w_hi_nx = w_gt ? w_mid : r_hi;
    assign w_more  = ({1'b0, w_lo_nx} + 1'b1) < {1'b0, w_hi_nx};
    assign w_more0 = w_n > NW'(2);

    assign w_idx      = r_lo[IW-1:0];
    assign w_bi       = r_b[IW-1:0];
    assign w_prog_nx  = (r_prog != 24'hFFFFFF) ? r_prog + 24'd1 : r_prog;
    assign w_hit_last = w_prog_nx < w_per;
    assign w_run_last = (r_b + NW'(1)) == r_nb;

    // Restoring divider step; the remainder stays below the period.
    assign w_c  = r_hits[w_bi];
    assign w_sh = {r_rem, 1'b0};
    assign w_ge = w_sh >= {1'b0, w_per};

    // One multiplier serves both products of the blend.
    assign w_ma   = (r_state == ST_MUL1) ? w_inv : w_alpha;
    assign w_mb   = (r_state == ST_MUL1) ? r_hot[w_bi] : r_q;
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    assign w_hsum = SW'(r_p1 >> 16) + SW'(r_p2 >> 16);
    assign w_hnew = (w_hsum > SW'(ONE)) ? ONE : w_hsum[HW-1:0];

    krht_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (BUCKETS + 1)
    ) u_bounds (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_opcode == OP_LOAD && {1'b0, i_slot} <= 7'(BUCKETS)),
        .i_waddr (i_slot[AW-1:0]),
        .i_wdata (i_search_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_opcode == OP_HIT) begin
                    n_state = w_more0 ? ST_RD : ST_HIT;
                end
            end
            ST_RD:       n_state = ST_CMP;
            ST_CMP:      n_state = w_more ? ST_RD : ST_HIT;
            ST_HIT: begin
                if (w_free) begin
                    n_state = w_hit_last ? ST_IDLE : ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: n_state = (w_c >= w_per) ? ST_MUL1 : ST_DIV;
            ST_DIV:      n_state = (r_cnt == CW'(FRAC_BITS - 1)) ? ST_MUL1 : ST_DIV;
            ST_MUL1:     n_state = ST_MUL2;
            ST_MUL2:     n_state = ST_SUM;
            ST_SUM: begin
                if (w_free) begin
                    n_state = w_run_last ? ST_IDLE : ST_DIV_INIT;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_prog      <= '0;
            r_bc        <= BOUNDARY_COUNT_RST;
            r_alpha     <= SMOOTHING_RST;
            r_per       <= PERIOD_RST;
            for (int i = 0; i < BUCKETS; i++) begin
                r_hits[i] <= '0;
                r_hot[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOUNDARY_COUNT: r_bc    <= i_cfg_data[5:0];
                    CFG_SMOOTHING:      r_alpha <= i_cfg_data[16:0];
                    CFG_PERIOD:         r_per   <= i_cfg_data;
                    default:            ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_key <= i_search_key;
                    r_lo  <= '0;
                    r_hi  <= w_n - NW'(1);
                    r_nb  <= w_n - NW'(1);
                end
                ST_RD: ;
                ST_CMP: begin
                    r_lo <= w_lo_nx;
                    r_hi <= w_hi_nx;
                end
                ST_HIT: begin
                    r_b <= '0;
                    if (w_free) begin
                        if (r_hits[w_idx] != 24'hFFFFFF) begin
                            r_hits[w_idx] <= r_hits[w_idx] + 24'd1;
                        end
                        r_prog      <= w_prog_nx;
                        r_kind      <= KIND_HIT;
                        r_bidx      <= w_idx;
                        r_hotv      <= r_hot[w_idx];
                        r_last      <= w_hit_last;
                    end
                end
                ST_DIV_INIT: begin
                    r_rem <= w_c;
                    r_q   <= (w_c >= w_per) ? ONE : '0;
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    r_rem <= w_ge ? 24'(w_sh - {1'b0, w_per}) : w_sh[23:0];
                    r_q   <= {r_q[HW-2:0], w_ge};
                    r_cnt <= r_cnt + CW'(1);
                end
                ST_MUL1: r_p1 <= w_prod;
                ST_MUL2: r_p2 <= w_prod;
                ST_SUM: begin
                    if (w_free) begin
                        r_hot[w_bi] <= w_hnew;
                        r_kind      <= KIND_HOT;
                        r_bidx      <= w_bi;
                        r_hotv      <= w_hnew;
                        r_last      <= w_run_last;
                        r_b         <= r_b + NW'(1);
                        if (w_run_last) begin
                            r_prog <= '0;
                            for (int i = 0; i < BUCKETS; i++) begin
                                r_hits[i] <= '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_kind   = r_kind;
    assign o_bucket_index  = r_bidx;
    assign o_hotness_value = r_hotv;
    assign o_last_of_run   = r_last;

`ifndef NO_ASSERTIONS
    // The search window never collapses while a step is pending.
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_CMP) |-> ({1'b0, r_lo} + 1'b1) < {1'b0, r_hi})
        else $error("search window collapsed");

    // Reported buckets stay inside the buckets in use.
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_out_valid) |-> {1'b0, r_bidx} < (IW + 1)'(r_nb))
        else $error("bucket index out of range");

    // Hotness never exceeds one.
    a_hot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_hotv <= ONE)
        else $error("hotness above one");

    // The closing beat of a recompute run clears the period.
    a_period_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && w_free && w_run_last) |=> (r_prog == 24'd0 && r_state == ST_IDLE))
        else $error("period not cleared at end of run");
`endif
endmodule

>>> tb/sv/tb_key_range_heat_tracker_unit.sv
// Self-checking testbench for key_range_heat_tracker_unit: boundary loads, range hits and
// the per-period hotness runs, compared beat by beat against an in-bench predictor.
// Depends on krht_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_key_range_heat_tracker_unit;
    import krht_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [4:0]  bucket;
        logic [16:0] heat;
        logic        last;
    } t_heat_beat;

    class krht_scoreboard;
        logic [63:0] bounds[33];
        logic [23:0] hit_cnt[32];
        logic [16:0] heat[32];
        logic [23:0] progress;
        logic [5:0]  bnd_count;
        logic [16:0] weight;
        logic [23:0] period;
        t_heat_beat  pending[$];
        int          mismatches;
        int          beats_seen;
        int          periods_done;

        function void clear();
            foreach (hit_cnt[b]) begin
                hit_cnt[b] = '0;
                heat[b] = '0;
            end
            foreach (bounds[b]) bounds[b] = '0;
            progress = '0;
            bnd_count = BOUNDARY_COUNT_RST;
            weight = SMOOTHING_RST;
            period = PERIOD_RST;
            mismatches = 0;
            beats_seen = 0;
            periods_done = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                CFG_BOUNDARY_COUNT: bnd_count = data[5:0];
                CFG_SMOOTHING:      weight = data[16:0];
                CFG_PERIOD:         period = data;
                default: ;
            endcase
        endfunction

        // Updates the model with one accepted input beat and queues the beats it causes.
        function void note_input(logic op, logic [5:0] slot, logic [63:0] key);
            int unsigned n, lo, hi, mid, idx, per, alpha;
            longint unsigned ratio, h;
            t_heat_beat e;
            if (op == OP_LOAD) begin
                if (slot <= 32) bounds[slot] = key;
                return;
            end
            n = bnd_count < 2 ? 2 : (bnd_count > 33 ? 33 : bnd_count);
            lo = 0;
            hi = n - 1;
            while (lo + 1 < hi) begin
                mid = lo + (hi - lo) / 2;
                if (bounds[mid] > key) hi = mid;
                else lo = mid;
            end
            idx = lo;
            if (hit_cnt[idx] != 24'hFFFFFF) hit_cnt[idx] = hit_cnt[idx] + 24'd1;
            if (progress != 24'hFFFFFF) progress = progress + 24'd1;
            per = period == 0 ? 1 : period;
            alpha = weight > 65536 ? 65536 : weight;
            e.kind = KIND_HIT;
            e.bucket = idx[4:0];
            e.heat = heat[idx];
            e.last = progress < per;
            pending = {pending, e};
            if (progress < per) return;
            periods_done++;
            for (int b = 0; b < n - 1; b++) begin
                ratio = (longint'(hit_cnt[b]) << 16) / per;
                if (ratio > 65536) ratio = 65536;
                h = ((longint'(65536 - alpha) * heat[b]) >> 16)
                  + ((longint'(alpha) * ratio) >> 16);
                if (h > 65536) h = 65536;
                heat[b] = h[16:0];
                e.kind = KIND_HOT;
                e.bucket = b[4:0];
                e.heat = heat[b];
                e.last = (b + 1 == n - 1);
                pending = {pending, e};
            end
            foreach (hit_cnt[b]) hit_cnt[b] = '0;
            progress = '0;
        endfunction

        function void check_result(t_heat_beat got);
            t_heat_beat want;
            beats_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat kind=%0d bucket=%0d heat=%0d last=%0d",
                             got.kind, got.bucket, got.heat, got.last);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: beat %0d expected kind=%0d bucket=%0d heat=%0d last=%0d,",
                             beats_seen, want.kind, want.bucket, want.heat, want.last);
                    $display("       got kind=%0d bucket=%0d heat=%0d last=%0d",
                             got.kind, got.bucket, got.heat, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_opcode = OP_LOAD;
    logic [5:0]  i_slot = '0;
    logic [63:0] i_search_key = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_report_kind;
    logic [4:0]  o_bucket_index;
    logic [16:0] o_hotness_value;
    logic        o_last_of_run;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    krht_scoreboard heat_sb;
    bit quiet = 1'b0;
    int items_sent = 0;
    int hits_sent = 0;

    key_range_heat_tracker_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            heat_sb.check_result({o_report_kind, o_bucket_index, o_hotness_value, o_last_of_run});
    end

    // Receiver backpressure in random bursts, switched off once the run goes quiet.
    initial begin
        forever begin
            if (quiet || $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_beat(logic op, logic [5:0] slot, logic [63:0] key);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_slot <= slot;
        i_search_key <= key;
        do @(posedge i_clk); while (o_in_stall);
        heat_sb.note_input(op, slot, key);
        items_sent++;
        if (op == OP_HIT) hits_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (heat_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Leaves the write valid high; the caller drops it after its last write.
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        heat_sb.set_reg(idx, data);
    endtask

    task automatic configure(logic [23:0] cnt, logic [23:0] w, logic [23:0] per);
        drain();
        write_reg(CFG_BOUNDARY_COUNT, cnt);
        write_reg(CFG_SMOOTHING, w);
        write_reg(CFG_PERIOD, per);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads all 33 boundaries; sorted tables use an insertion sort, narrow ones may repeat keys.
    task automatic load_table(bit sorted, bit narrow);
        logic [63:0] vals[33];
        logic [63:0] tmp;
        int j;
        foreach (vals[k])
            vals[k] = narrow ? 64'($urandom_range(0, 300)) : {$urandom, $urandom};
        if (sorted) begin
            for (int k = 1; k < 33; k++) begin
                tmp = vals[k];
                j = k - 1;
                while (j >= 0 && vals[j] > tmp) begin
                    vals[j + 1] = vals[j];
                    j--;
                end
                vals[j + 1] = tmp;
            end
        end
        for (int k = 0; k < 33; k++) send_beat(OP_LOAD, 6'(k), vals[k]);
    endtask

    function automatic logic [63:0] pick_key();
        logic [63:0] b;
        b = heat_sb.bounds[$urandom_range(0, 32)];
        case ($urandom_range(0, 5))
            0: return b;
            1: return b + 64'd1;
            2: return b - 64'd1;
            3: return {$urandom, $urandom};
            4: return $urandom_range(0, 1) ? 64'd0 : '1;
            default: return b + 64'($urandom_range(0, 50));
        endcase
    endfunction

    initial begin
        int phase_hits;
        heat_sb = new();
        heat_sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full sorted table, ignored out-of-range slots, search extremes.
        configure(24'd33, 24'd65536, 24'd5);
        load_table(1, 0);
        send_beat(OP_LOAD, 6'd33, '1);
        send_beat(OP_LOAD, 6'd63, '0);
        send_beat(OP_HIT, 6'd0, 64'd0);
        send_beat(OP_HIT, 6'd63, '1);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[16]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[16] - 64'd1);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[32]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[1]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[0]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[31]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[5]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[20]);
        // Count below range clamps to one bucket, weight zero, period zero acts as one.
        configure(24'd0, 24'd0, 24'd0);
        send_beat(OP_HIT, 6'd0, '1);
        send_beat(OP_HIT, 6'd0, 64'd0);
        // Count above range, weight above one, longest period, then shortened mid-period.
        configure(24'd63, 24'h1FFFF, 24'hFFFFFF);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[3]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[3]);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[30]);
        configure(24'd1, 24'd40000, 24'd1);
        send_beat(OP_HIT, 6'd0, heat_sb.bounds[9]);

        // Random phases with fresh settings; the final stretch runs without idling.
        while (items_sent < 190) begin
            if (items_sent > 150) quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: configure(24'($urandom_range(0, 63)), 24'($urandom_range(0, 131071)),
                             24'($urandom_range(0, 3)));
                1: configure(24'd33, 24'd65536, 24'($urandom_range(1, 12)));
                default: configure(24'($urandom_range(2, 33)), 24'($urandom_range(0, 65536)),
                                   24'($urandom_range(1, 12)));
            endcase
            if ($urandom_range(0, 3) == 0)
                load_table($urandom_range(0, 4) != 0, $urandom_range(0, 1) != 0);
            phase_hits = $urandom_range(10, 30);
            repeat (phase_hits) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_LOAD, 6'($urandom_range(0, 63)), {$urandom, $urandom});
                else
                    send_beat(OP_HIT, 6'($urandom), pick_key());
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d input beats (%0d hits), %0d result beats, %0d period recomputes.",
                 items_sent, hits_sent, heat_sb.beats_seen, heat_sb.periods_done);
        if (heat_sb.mismatches == 0 && heat_sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d beats still expected.",
                     heat_sb.mismatches, heat_sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/krht_pkg.sv
hw/rtl/krht_ram.sv
hw/rtl/key_range_heat_tracker_unit.sv
tb/sv/tb_key_range_heat_tracker_unit.sv
